>>> hw/rtl/dese_pkg.sv
// ----------------------------------------------------------------------------
// dese_pkg
// Shared types and constants for the double-ended sequence store.
// ----------------------------------------------------------------------------
package dese_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_BITS  = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths of the request and result ports
    localparam int OP_BITS    = 3;
    localparam int INDEX_BITS = 4;
    localparam int STAT_BITS  = 2;
    localparam int COUNT_BITS = 5;

    // Request opcodes
    localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_READ_IDX   = 3'd4;
    localparam logic [OP_BITS-1:0] OP_WRITE_IDX  = 3'd5;

    // Result status codes
    localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd3;

    // Cell update modes
    localparam logic [1:0] CM_HOLD       = 2'd0;
    localparam logic [1:0] CM_LOAD       = 2'd1;
    localparam logic [1:0] CM_SHIFT_UP   = 2'd2;
    localparam logic [1:0] CM_SHIFT_DOWN = 2'd3;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic [1:0]           mode;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_BITS-1:0] word;
    } t_cell_cmd;

endpackage

>>> hw/rtl/dese_cell.sv
// ----------------------------------------------------------------------------
// dese_cell
// One storage cell of the chain: holds a word, loads, or takes a neighbor's.
// ----------------------------------------------------------------------------
module dese_cell (
    input  logic                               i_clk,
    input  logic [dese_pkg::ADDR_W-1:0]        i_pos,
    input  dese_pkg::t_cell_cmd                i_cmd,
    input  logic [dese_pkg::WORD_BITS-1:0]     i_lower_word,
    input  logic [dese_pkg::WORD_BITS-1:0]     i_upper_word,
    output logic [dese_pkg::WORD_BITS-1:0]     o_word,
    output logic [dese_pkg::WORD_BITS-1:0]     o_rd_word
);

    logic [dese_pkg::WORD_BITS-1:0] r_word;
    logic [dese_pkg::WORD_BITS-1:0] n_word;
    logic                           w_hit;

    assign w_hit = (i_pos == i_cmd.addr);

    always_comb begin
        n_word = r_word;
        unique case (i_cmd.mode)
            dese_pkg::CM_HOLD: begin
                n_word = r_word;
            end
            dese_pkg::CM_LOAD: begin
                if (w_hit) begin
                    n_word = i_cmd.word;
                end
            end
            dese_pkg::CM_SHIFT_UP: begin
                // front cell takes the new word, the rest take from below
                if (i_pos == '0) begin
                    n_word = i_cmd.word;
                end else begin
                    n_word = i_lower_word;
                end
            end
            dese_pkg::CM_SHIFT_DOWN: begin
                n_word = i_upper_word;
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word    = r_word;
    assign o_rd_word = w_hit ? r_word : '0;

endmodule

>>> hw/rtl/double_ended_sequence_store_top.sv
// ----------------------------------------------------------------------------
// double_ended_sequence_store_top
// Fixed-capacity double-ended queue built from a chain of word cells.
// ----------------------------------------------------------------------------
// Each request (push back, push front, pop back, pop front, read at index,
// write at index) returns one result: data word, status and count after the
// request. The result of a taken request appears in the output register in the
// cycle after; one request per cycle is sustained while the result side keeps
// taking results. Front inserts and removes move every held word one cell at
// once, at the clock edge that takes the request. Reads select one cell
// through a match-and-OR across the chain.
module double_ended_sequence_store_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [dese_pkg::OP_BITS-1:0]        i_op,
    input  logic [dese_pkg::WORD_BITS-1:0]      i_data_in,
    input  logic [dese_pkg::INDEX_BITS-1:0]     i_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dese_pkg::WORD_BITS-1:0]      o_data_out,
    output logic [dese_pkg::STAT_BITS-1:0]      o_status,
    output logic [dese_pkg::COUNT_BITS-1:0]     o_count
);

    localparam int N = dese_pkg::DEPTH;

    logic [dese_pkg::CNT_W-1:0]      r_count;
    logic [dese_pkg::CNT_W-1:0]      n_count;
    logic                            r_out_valid;
    logic [dese_pkg::WORD_BITS-1:0]  r_data_out;
    logic [dese_pkg::STAT_BITS-1:0]  r_status;
    logic [dese_pkg::COUNT_BITS-1:0] r_res_count;

    logic                            w_accept;
    logic [dese_pkg::WORD_BITS-1:0]  w_data;
    logic                            w_rd_sel;
    logic [dese_pkg::STAT_BITS-1:0]  w_status;
    logic [1:0]                      w_mode;
    logic [dese_pkg::ADDR_W-1:0]     w_addr;
    logic [dese_pkg::WORD_BITS-1:0]  w_rd;
    dese_pkg::t_cell_cmd             w_cmd;

    logic [dese_pkg::WORD_BITS-1:0]  w_word    [N];
    logic [dese_pkg::WORD_BITS-1:0]  w_rd_word [N];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Request decode: selects the cell to read, the chain update, the status and the new count
    always_comb begin
        w_status = dese_pkg::ST_OK;
        w_rd_sel = 1'b0;
        w_mode   = dese_pkg::CM_HOLD;
        w_addr   = '0;
        n_count  = r_count;
        unique case (i_op)
            dese_pkg::OP_PUSH_BACK: begin
                if (int'(r_count) >= N) begin
                    w_status = dese_pkg::ST_FULL;
                end else begin
                    w_mode  = dese_pkg::CM_LOAD;
                    w_addr  = r_count[dese_pkg::ADDR_W-1:0];
                    n_count = r_count + 1'b1;
                end
            end
            dese_pkg::OP_PUSH_FRONT: begin
                if (int'(r_count) >= N) begin
                    w_status = dese_pkg::ST_FULL;
                end else begin
                    w_mode  = dese_pkg::CM_SHIFT_UP;
                    n_count = r_count + 1'b1;
                end
            end
            dese_pkg::OP_POP_BACK: begin
                if (r_count == '0) begin
                    w_status = dese_pkg::ST_EMPTY;
                end else begin
                    n_count  = r_count - 1'b1;
                    w_addr   = n_count[dese_pkg::ADDR_W-1:0];
                    w_rd_sel = 1'b1;
                end
            end
            dese_pkg::OP_POP_FRONT: begin
                if (r_count == '0) begin
                    w_status = dese_pkg::ST_EMPTY;
                end else begin
                    w_mode   = dese_pkg::CM_SHIFT_DOWN;
                    n_count  = r_count - 1'b1;
                    w_rd_sel = 1'b1;
                end
            end
            dese_pkg::OP_READ_IDX: begin
                if (int'(i_index) >= int'(r_count)) begin
                    w_status = dese_pkg::ST_RANGE;
                end else begin
                    w_addr   = dese_pkg::ADDR_W'(i_index);
                    w_rd_sel = 1'b1;
                end
            end
            dese_pkg::OP_WRITE_IDX: begin
                if (int'(i_index) >= int'(r_count)) begin
                    w_status = dese_pkg::ST_RANGE;
                end else begin
                    w_mode = dese_pkg::CM_LOAD;
                    w_addr = dese_pkg::ADDR_W'(i_index);
                end
            end
            default: begin
                w_status = dese_pkg::ST_RANGE;
            end
        endcase
    end

    assign w_data = w_rd_sel ? w_rd : '0;

    // Hold the chain unless the request is taken this cycle
    assign w_cmd.mode = w_accept ? w_mode : dese_pkg::CM_HOLD;
    assign w_cmd.addr = w_addr;
    assign w_cmd.word = i_data_in;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [dese_pkg::WORD_BITS-1:0] w_lower;
            logic [dese_pkg::WORD_BITS-1:0] w_upper;
            if (g == 0) begin : g_first
                assign w_lower = '0;
            end else begin : g_mid_lo
                assign w_lower = w_word[g-1];
            end
            if (g == N - 1) begin : g_last
                assign w_upper = '0;
            end else begin : g_mid_hi
                assign w_upper = w_word[g+1];
            end
            dese_cell u_cell (
                .i_clk        (i_clk),
                .i_pos        (dese_pkg::ADDR_W'(g)),
                .i_cmd        (w_cmd),
                .i_lower_word (w_lower),
                .i_upper_word (w_upper),
                .o_word       (w_word[g]),
                .o_rd_word    (w_rd_word[g])
            );
        end
    endgenerate

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < N; k++) begin
            w_rd = w_rd | w_rd_word[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_out  <= w_data;
            r_status    <= w_status;
            r_res_count <= dese_pkg::COUNT_BITS'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_count     = r_res_count;

endmodule

>>> hw/rtl/dese_checker.sv
// ----------------------------------------------------------------------------
// dese_checker
// Port-level checks for the double-ended sequence store, bound to the top.
// ----------------------------------------------------------------------------
module dese_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [dese_pkg::WORD_BITS-1:0]      o_data_out,
    input  logic [dese_pkg::STAT_BITS-1:0]      o_status,
    input  logic [dese_pkg::COUNT_BITS-1:0]     o_count
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_data_out) && $stable(o_status)
             && $stable(o_count)))
        else $error("stalled result changed");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == dese_pkg::ST_FULL) |->
            (o_count == dese_pkg::COUNT_BITS'(dese_pkg::DEPTH)))
        else $error("full status with count below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == dese_pkg::ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with nonzero count");

    a_err_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != dese_pkg::ST_OK) |-> (o_data_out == '0))
        else $error("error result carries data");

    // A request is taken only when the result register can accept it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken over a pending result");

endmodule

bind double_ended_sequence_store_top dese_checker u_dese_checker (.*);

>>> dv/double_ended_sequence_store_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_sequence_store_top_test
// Self-checking testbench for the double-ended sequence store.
// ----------------------------------------------------------------------------
// Requests go in one at a time through the valid/ready request port. A local
// shadow of the store predicts the data, status and count that each accepted
// request must return, and a checker compares every returned result with the
// oldest prediction. Directed requests cover empty and full stores, index
// bounds and undefined opcodes. Random fill/drain waves follow under several
// sender and receiver idling mixes, plus one long result-side hold.
module double_ended_sequence_store_top_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 240;
    localparam int DRAIN_CYCLES = 8;

    // Opcodes the block does not define
    localparam logic [dese_pkg::OP_BITS-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [dese_pkg::OP_BITS-1:0] OP_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [dese_pkg::WORD_BITS-1:0]  data;
        logic [dese_pkg::STAT_BITS-1:0]  status;
        logic [dese_pkg::COUNT_BITS-1:0] count;
    } t_queue_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    logic [dese_pkg::OP_BITS-1:0]     i_op = '0;
    logic [dese_pkg::WORD_BITS-1:0]   i_data_in = '0;
    logic [dese_pkg::INDEX_BITS-1:0]  i_index = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [dese_pkg::WORD_BITS-1:0]   o_data_out;
    logic [dese_pkg::STAT_BITS-1:0]   o_status;
    logic [dese_pkg::COUNT_BITS-1:0]  o_count;

    // Shadow of the store contents and fill level
    logic [dese_pkg::WORD_BITS-1:0]   shadow_words [dese_pkg::DEPTH];
    int                               held_words = 0;
    bit                               filling = 1'b1;

    t_queue_result                    pending_results [$];
    int                               mismatches = 0;
    int                               requests_sent = 0;
    int                               results_checked = 0;
    int                               status_seen [4] = '{0, 0, 0, 0};
    int                               cycle_count = 0;

    int                               send_idle_pct = 0;
    int                               recv_stall_pct = 0;
    int                               hold_requests = 0;
    int                               hold_served = 0;
    int                               hold_left = 0;

    double_ended_sequence_store_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_data_in   (i_data_in),
        .i_index     (i_index),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("double_ended_sequence_store_top test failed");
            $finish;
        end
    end

    function automatic t_queue_result predict_request(
        input logic [dese_pkg::OP_BITS-1:0]    op,
        input logic [dese_pkg::WORD_BITS-1:0]  word,
        input logic [dese_pkg::INDEX_BITS-1:0] idx
    );
        t_queue_result res;
        res.data   = '0;
        res.status = dese_pkg::ST_OK;
        case (op)
            dese_pkg::OP_PUSH_BACK: begin
                if (held_words >= dese_pkg::DEPTH) begin
                    res.status = dese_pkg::ST_FULL;
                end else begin
                    shadow_words[held_words] = word;
                    held_words++;
                end
            end
            dese_pkg::OP_PUSH_FRONT: begin
                if (held_words >= dese_pkg::DEPTH) begin
                    res.status = dese_pkg::ST_FULL;
                end else begin
                    for (int i = held_words; i > 0; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[0] = word;
                    held_words++;
                end
            end
            dese_pkg::OP_POP_BACK: begin
                if (held_words == 0) begin
                    res.status = dese_pkg::ST_EMPTY;
                end else begin
                    held_words--;
                    res.data = shadow_words[held_words];
                end
            end
            dese_pkg::OP_POP_FRONT: begin
                if (held_words == 0) begin
                    res.status = dese_pkg::ST_EMPTY;
                end else begin
                    res.data = shadow_words[0];
                    held_words--;
                    for (int i = 0; i < held_words; i++)
                        shadow_words[i] = shadow_words[i+1];
                end
            end
            dese_pkg::OP_READ_IDX: begin
                if (int'(idx) >= held_words) begin
                    res.status = dese_pkg::ST_RANGE;
                end else begin
                    res.data = shadow_words[idx];
                end
            end
            dese_pkg::OP_WRITE_IDX: begin
                if (int'(idx) >= held_words) begin
                    res.status = dese_pkg::ST_RANGE;
                end else begin
                    shadow_words[idx] = word;
                end
            end
            default: begin
                res.status = dese_pkg::ST_RANGE;
            end
        endcase
        res.count = dese_pkg::COUNT_BITS'(held_words);
        status_seen[res.status]++;
        return res;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [dese_pkg::WORD_BITS-1:0] got,
                                   input logic [dese_pkg::WORD_BITS-1:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Result checker: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result data", o_data_out, '0);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_data_out !== want.data)
                    report_mismatch("data_out", o_data_out, want.data);
                if (o_status !== want.status)
                    report_mismatch("status", dese_pkg::WORD_BITS'(o_status),
                                    dese_pkg::WORD_BITS'(want.status));
                if (o_count !== want.count)
                    report_mismatch("count", dese_pkg::WORD_BITS'(o_count),
                                    dese_pkg::WORD_BITS'(want.count));
            end
        end
    end

    // Result-side ready: random stalls, or a long hold when one is requested
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    // Offer one request, wait for it to be taken, then record its prediction
    task automatic send_request(input logic [dese_pkg::OP_BITS-1:0] op,
                                input logic [dese_pkg::WORD_BITS-1:0] word,
                                input logic [dese_pkg::INDEX_BITS-1:0] idx);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_data_in  <= word;
        i_index    <= idx;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
        pending_results.push_back(predict_request(op, word, idx));
        requests_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [dese_pkg::WORD_BITS-1:0] pick_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return dese_pkg::WORD_BITS'($urandom);
        endcase
    endfunction

    // Fill/drain waves: pushes dominate while filling, pops while draining
    task automatic send_random_request();
        logic [dese_pkg::OP_BITS-1:0]    op;
        logic [dese_pkg::INDEX_BITS-1:0] idx;
        int                              r;
        if (held_words == dese_pkg::DEPTH)
            filling = 1'b0;
        else if (held_words == 0)
            filling = 1'b1;
        else if ($urandom_range(99) < 3)
            filling = ~filling;
        r = $urandom_range(99);
        if (r < 2) begin
            op = $urandom_range(1) ? OP_UNDEF_HI : OP_UNDEF_LO;
        end else if (r < 62) begin
            if (int'($urandom_range(99)) < (filling ? 75 : 25))
                op = $urandom_range(1) ? dese_pkg::OP_PUSH_FRONT : dese_pkg::OP_PUSH_BACK;
            else
                op = $urandom_range(1) ? dese_pkg::OP_POP_FRONT : dese_pkg::OP_POP_BACK;
        end else if (r < 82) begin
            op = dese_pkg::OP_READ_IDX;
        end else begin
            op = dese_pkg::OP_WRITE_IDX;
        end
        if (held_words > 0 && $urandom_range(9) < 8)
            idx = dese_pkg::INDEX_BITS'($urandom_range(held_words - 1));
        else
            idx = dese_pkg::INDEX_BITS'($urandom_range(dese_pkg::DEPTH - 1));
        send_request(op, pick_word(), idx);
    endtask

    task automatic test_empty_store();
        send_request(dese_pkg::OP_POP_BACK, pick_word(), '0);
        send_request(dese_pkg::OP_POP_FRONT, pick_word(), '0);
        send_request(dese_pkg::OP_READ_IDX, pick_word(), '0);
        send_request(dese_pkg::OP_WRITE_IDX, '1, '1);
        send_request(OP_UNDEF_LO, '1, '0);
        send_request(OP_UNDEF_HI, '0, '1);
        wait_idle();
    endtask

    task automatic test_fill_to_full();
        send_request(dese_pkg::OP_PUSH_FRONT, '1, '0);
        send_request(dese_pkg::OP_PUSH_BACK, '0, '1);
        send_request(dese_pkg::OP_READ_IDX, pick_word(), 4'd1);
        send_request(dese_pkg::OP_READ_IDX, pick_word(), 4'd2);   // index equal to count
        send_request(dese_pkg::OP_WRITE_IDX, dese_pkg::WORD_BITS'($urandom), 4'd1);
        for (int i = 0; i < dese_pkg::DEPTH - 2; i++)
            send_request((i % 2) ? dese_pkg::OP_PUSH_FRONT : dese_pkg::OP_PUSH_BACK,
                         dese_pkg::WORD_BITS'($urandom), '0);
        send_request(dese_pkg::OP_PUSH_BACK, pick_word(), '0);
        send_request(dese_pkg::OP_PUSH_FRONT, pick_word(), '0);
        send_request(dese_pkg::OP_WRITE_IDX, '1, '1);
        send_request(dese_pkg::OP_READ_IDX, pick_word(), '1);
        send_request(dese_pkg::OP_POP_FRONT, pick_word(), '0);
        send_request(dese_pkg::OP_POP_BACK, pick_word(), '0);
        send_request(OP_UNDEF_HI, '1, '1);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n_requests, input int idle_pct,
                                       input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_requests) send_random_request();
        wait_idle();
    endtask

    // Hold the result side for a long stretch while requests keep coming
    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests <= hold_requests + 1;
        repeat (60) send_random_request();
        wait_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_fill_to_full();
        test_random_traffic(300, 0, 0);
        test_random_traffic(300, 53, 0);
        test_random_traffic(300, 0, 53);
        test_random_traffic(300, 8, 8);
        test_result_backpressure();

        $display("Covered empty and full stores, index bounds, undefined opcodes, idling mixes");
        $display("and a long result hold: %0d of %0d requests checked (ok %0d, full %0d, %s",
                 results_checked, requests_sent, status_seen[dese_pkg::ST_OK],
                 status_seen[dese_pkg::ST_FULL],
                 $sformatf("empty %0d, range %0d).", status_seen[dese_pkg::ST_EMPTY],
                           status_seen[dese_pkg::ST_RANGE]));
        if (mismatches == 0) begin
            $display("double_ended_sequence_store_top test passed");
        end else begin
            $display("double_ended_sequence_store_top test failed");
        end
        $finish;
    end

endmodule
